// File: hdl/pat_pkg.sv
// operation and status codes plus field widths for the positional array table
`default_nettype none

package pat_pkg;

  // fixed field widths of the stream payload
  localparam int unsigned OP_W       = 3;
  localparam int unsigned POS_W      = 7;
  localparam int unsigned VAL_W      = 32;
  localparam int unsigned STAT_W     = 3;
  localparam int unsigned CNT_W      = 7;
  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 48;

  // request operations
  typedef enum logic [OP_W-1:0] {
    OP_APPEND   = 3'd0,
    OP_INSERT   = 3'd1,
    OP_DELETE   = 3'd2,
    OP_SEARCH   = 3'd3,
    OP_UPDATE   = 3'd4,
    OP_TRAVERSE = 3'd5
  } op_e;

  // result status codes
  typedef enum logic [STAT_W-1:0] {
    STAT_OK        = 3'd0,
    STAT_NOT_FOUND = 3'd1,
    STAT_BAD_POS   = 3'd2,
    STAT_FULL      = 3'd3,
    STAT_EMPTY     = 3'd4
  } status_e;

endpackage

`default_nettype wire

// File: hdl/pat_mem.sv
// entry store: one write port and one registered read port
`default_nettype none

module pat_mem #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: hdl/positional_array_table.sv
// top level of the positional array table: request sequencer around the entry store
//
//  channel  dir  tdata (low bit up)                        tuser    tlast
//  s_axis   in   position[6:0] value[38:7] pad[39]         op[2:0]  -
//  m_axis   out  result_value[31:0] result_position[38:32]  status   last
//                count[45:39] pad[47:46]
//
// one request at a time; append, update and every error answer pass straight to the result beat
// insert and delete shift the tail of the table, walking
// the entry store one entry a cycle through its single read and write port
// search stops at its first match and traverse emits every entry, both held by output stalls
// reset clears the count and the sequencer registers but not the entry store; entries are undefined until written
// the output register lets a new request enter while the last beat waits
`default_nettype none

module positional_array_table #(
  parameter int unsigned DEPTH      = 64,
  parameter int unsigned WORD_WIDTH = 32
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // request stream
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire logic [pat_pkg::IN_DATA_W-1:0]   s_axis_tdata,  // position, value
  input  wire logic [pat_pkg::OP_W-1:0]        s_axis_tuser,  // op
  // result stream
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  output logic      [pat_pkg::OUT_DATA_W-1:0]  m_axis_tdata,  // value, position, count
  output logic      [pat_pkg::STAT_W-1:0]      m_axis_tuser,  // status
  output logic                                 m_axis_tlast
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned PW = ((CW > pat_pkg::POS_W) ? CW : pat_pkg::POS_W) + 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS,
    S_INS_LAST,
    S_DEL,
    S_SRCH,
    S_TRAV,
    S_RESP
  } state_e;

  state_e                        state_q, state_d;
  logic [CW-1:0]                 count_q, count_d;
  logic [CW-1:0]                 idx_q, idx_d;
  logic [CW-1:0]                 pos_q, pos_d;
  logic [WORD_WIDTH-1:0]         word_q, word_d;
  logic                          pend_v_q, pend_v_d;
  logic [CW-1:0]                 pend_addr_q, pend_addr_d;
  logic                          pend_first_q, pend_first_d;
  logic [WORD_WIDTH-1:0]         gone_q, gone_d;
  pat_pkg::status_e              res_status_q, res_status_d;
  logic [pat_pkg::VAL_W-1:0]     res_value_q, res_value_d;
  logic                          ov_q, ov_d;
  pat_pkg::status_e              o_status_q, o_status_d;
  logic [pat_pkg::VAL_W-1:0]     o_value_q, o_value_d;
  logic [pat_pkg::POS_W-1:0]     o_pos_q, o_pos_d;
  logic [pat_pkg::CNT_W-1:0]     o_cnt_q, o_cnt_d;
  logic                          o_last_q, o_last_d;

  // memory port signals
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [WORD_WIDTH-1:0] mem_wdata;
  logic                  mem_re;
  logic [AW-1:0]         mem_raddr;
  logic [WORD_WIDTH-1:0] mem_rdata;

  // decoded request fields
  logic [pat_pkg::POS_W-1:0]  in_pos;
  logic signed [pat_pkg::VAL_W-1:0] in_value;
  logic signed [63:0]         in_ext;
  logic [WORD_WIDTH-1:0]      in_word;
  logic [PW-1:0]              pos_x;
  logic [PW-1:0]              pos_m1_x;
  logic [PW-1:0]              cnt_x;
  logic                       full;
  logic                       accept;

  // helpers for the walk
  logic signed [63:0]         rd_ext;
  logic signed [63:0]         gone_ext;
  logic [PW-1:0]              pend_pos_x;
  logic [CW-1:0]              pa_inc;
  logic [CW-1:0]              pa_dec;
  logic [CW-1:0]              idx_inc;
  logic [CW-1:0]              idx_dec;
  logic [CW-1:0]              pos_dec;
  logic                       match;
  logic                       trav_last;
  logic                       out_space;

  // output load
  logic                       load;
  pat_pkg::status_e           ld_status;
  logic [pat_pkg::VAL_W-1:0]  ld_value;
  logic [pat_pkg::POS_W-1:0]  ld_pos;
  logic                       ld_last;

  pat_mem #(
    .DEPTH (DEPTH),
    .WIDTH (WORD_WIDTH)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // field decode and word conversion
  assign in_pos     = s_axis_tdata[pat_pkg::POS_W-1:0];
  assign in_value   = s_axis_tdata[pat_pkg::POS_W +: pat_pkg::VAL_W];
  assign in_ext     = 64'(in_value);
  assign in_word    = in_ext[WORD_WIDTH-1:0];
  assign pos_x      = PW'(in_pos);
  assign pos_m1_x   = pos_x - PW'(1);
  assign cnt_x      = PW'(count_q);
  assign full       = (cnt_x == PW'(DEPTH));
  assign rd_ext     = 64'(signed'(mem_rdata));
  assign gone_ext   = 64'(signed'(gone_q));
  assign pend_pos_x = PW'(pend_addr_q) + PW'(1);
  assign pa_inc     = pend_addr_q + CW'(1);
  assign pa_dec     = pend_addr_q - CW'(1);
  assign idx_inc    = idx_q + CW'(1);
  assign idx_dec    = idx_q - CW'(1);
  assign pos_dec    = pos_q - CW'(1);
  assign match      = (mem_rdata == word_q);
  assign trav_last  = (pend_pos_x == cnt_x);
  assign out_space  = !ov_q || m_axis_tready;

  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // sequencer next state
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    idx_d        = idx_q;
    pos_d        = pos_q;
    word_d       = word_q;
    pend_v_d     = pend_v_q;
    pend_addr_d  = pend_addr_q;
    pend_first_d = pend_first_q;
    gone_d       = gone_q;
    res_status_d = res_status_q;
    res_value_d  = res_value_q;
    mem_we       = 1'b0;
    mem_waddr    = pend_addr_q[AW-1:0];
    mem_wdata    = mem_rdata;
    mem_re       = 1'b0;
    mem_raddr    = idx_q[AW-1:0];
    load         = 1'b0;
    ld_status    = pat_pkg::STAT_OK;
    ld_value     = '0;
    ld_pos       = '0;
    ld_last      = 1'b1;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          word_d       = in_word;
          pos_d        = pos_x[CW-1:0];
          pend_v_d     = 1'b0;
          idx_d        = '0;
          res_value_d  = '0;
          res_status_d = pat_pkg::STAT_OK;
          state_d      = S_RESP;
          case (s_axis_tuser)
            pat_pkg::OP_APPEND: begin
              if (full) begin
                res_status_d = pat_pkg::STAT_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = count_q[AW-1:0];
                mem_wdata = in_word;
                count_d   = count_q + CW'(1);
              end
            end
            pat_pkg::OP_INSERT: begin
              if (full) begin
                res_status_d = pat_pkg::STAT_FULL;
              end else if (pos_x == '0 || pos_x > cnt_x + PW'(1)) begin
                res_status_d = pat_pkg::STAT_BAD_POS;
              end else begin
                idx_d   = count_q;
                state_d = S_INS;
              end
            end
            pat_pkg::OP_DELETE: begin
              if (count_q == '0) begin
                res_status_d = pat_pkg::STAT_EMPTY;
              end else if (pos_x == '0 || pos_x > cnt_x) begin
                res_status_d = pat_pkg::STAT_BAD_POS;
              end else begin
                idx_d   = pos_m1_x[CW-1:0];
                state_d = S_DEL;
              end
            end
            pat_pkg::OP_SEARCH: begin
              if (count_q == '0) begin
                res_status_d = pat_pkg::STAT_NOT_FOUND;
              end else begin
                state_d = S_SRCH;
              end
            end
            pat_pkg::OP_UPDATE: begin
              if (pos_x == '0 || pos_x > cnt_x) begin
                res_status_d = pat_pkg::STAT_BAD_POS;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = pos_m1_x[AW-1:0];
                mem_wdata = in_word;
              end
            end
            pat_pkg::OP_TRAVERSE: begin
              if (count_q == '0) begin
                res_status_d = pat_pkg::STAT_EMPTY;
              end else begin
                state_d = S_TRAV;
              end
            end
            default: begin
              res_status_d = pat_pkg::STAT_OK;
            end
          endcase
        end
      end

      // shift entries up, walking down from the end
      S_INS: begin
        if (pend_v_q) begin
          mem_we    = 1'b1;
          mem_waddr = pa_inc[AW-1:0];
          mem_wdata = mem_rdata;
        end
        if (idx_q >= pos_q) begin
          mem_re      = 1'b1;
          mem_raddr   = idx_dec[AW-1:0];
          pend_v_d    = 1'b1;
          pend_addr_d = idx_dec;
          idx_d       = idx_dec;
        end else begin
          pend_v_d = 1'b0;
          state_d  = S_INS_LAST;
        end
      end

      // place the new word once the shift has drained
      S_INS_LAST: begin
        mem_we       = 1'b1;
        mem_waddr    = pos_dec[AW-1:0];
        mem_wdata    = word_q;
        count_d      = count_q + CW'(1);
        res_status_d = pat_pkg::STAT_OK;
        res_value_d  = '0;
        state_d      = S_RESP;
      end

      // first read captures the removed word, later ones shift down
      S_DEL: begin
        if (pend_v_q) begin
          if (pend_first_q) begin
            gone_d = mem_rdata;
          end else begin
            mem_we    = 1'b1;
            mem_waddr = pa_dec[AW-1:0];
            mem_wdata = mem_rdata;
          end
        end
        if (idx_q < count_q) begin
          mem_re       = 1'b1;
          mem_raddr    = idx_q[AW-1:0];
          pend_v_d     = 1'b1;
          pend_addr_d  = idx_q;
          pend_first_d = (idx_inc == pos_q);
          idx_d        = idx_inc;
        end else begin
          pend_v_d = 1'b0;
          if (!pend_v_q) begin
            count_d      = count_q - CW'(1);
            res_status_d = pat_pkg::STAT_OK;
            res_value_d  = gone_ext[pat_pkg::VAL_W-1:0];
            state_d      = S_RESP;
          end
        end
      end

      // linear search, compare one entry a cycle
      S_SRCH: begin
        if (pend_v_q && match) begin
          if (out_space) begin
            load      = 1'b1;
            ld_status = pat_pkg::STAT_OK;
            ld_value  = rd_ext[pat_pkg::VAL_W-1:0];
            ld_pos    = pend_pos_x[pat_pkg::POS_W-1:0];
            ld_last   = 1'b1;
            pend_v_d  = 1'b0;
            state_d   = S_IDLE;
          end
        end else if (idx_q < count_q) begin
          mem_re      = 1'b1;
          mem_raddr   = idx_q[AW-1:0];
          pend_v_d    = 1'b1;
          pend_addr_d = idx_q;
          idx_d       = idx_inc;
        end else begin
          pend_v_d     = 1'b0;
          res_status_d = pat_pkg::STAT_NOT_FOUND;
          res_value_d  = '0;
          state_d      = S_RESP;
        end
      end

      // emit every entry, read ahead while the output drains
      S_TRAV: begin
        if (pend_v_q && out_space) begin
          load      = 1'b1;
          ld_status = pat_pkg::STAT_OK;
          ld_value  = rd_ext[pat_pkg::VAL_W-1:0];
          ld_pos    = pend_pos_x[pat_pkg::POS_W-1:0];
          ld_last   = trav_last;
          pend_v_d  = 1'b0;
          if (trav_last) begin
            state_d = S_IDLE;
          end
        end
        if ((!pend_v_q || out_space) && idx_q < count_q) begin
          mem_re      = 1'b1;
          mem_raddr   = idx_q[AW-1:0];
          pend_v_d    = 1'b1;
          pend_addr_d = idx_q;
          idx_d       = idx_inc;
        end
      end

      // single result beat
      S_RESP: begin
        if (out_space) begin
          load      = 1'b1;
          ld_status = res_status_q;
          ld_value  = res_value_q;
          ld_pos    = '0;
          ld_last   = 1'b1;
          state_d   = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // output register next value
  always_comb begin
    ov_d       = ov_q;
    o_status_d = o_status_q;
    o_value_d  = o_value_q;
    o_pos_d    = o_pos_q;
    o_cnt_d    = o_cnt_q;
    o_last_d   = o_last_q;
    if (load) begin
      ov_d       = 1'b1;
      o_status_d = ld_status;
      o_value_d  = ld_value;
      o_pos_d    = ld_pos;
      o_cnt_d    = cnt_x[pat_pkg::CNT_W-1:0];
      o_last_d   = ld_last;
    end else if (m_axis_tready) begin
      ov_d = 1'b0;
    end
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      count_q      <= '0;
      idx_q        <= '0;
      pos_q        <= '0;
      word_q       <= '0;
      pend_v_q     <= 1'b0;
      pend_addr_q  <= '0;
      pend_first_q <= 1'b0;
      gone_q       <= '0;
      res_status_q <= pat_pkg::STAT_OK;
      res_value_q  <= '0;
      ov_q         <= 1'b0;
      o_status_q   <= pat_pkg::STAT_OK;
      o_value_q    <= '0;
      o_pos_q      <= '0;
      o_cnt_q      <= '0;
      o_last_q     <= 1'b0;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      idx_q        <= idx_d;
      pos_q        <= pos_d;
      word_q       <= word_d;
      pend_v_q     <= pend_v_d;
      pend_addr_q  <= pend_addr_d;
      pend_first_q <= pend_first_d;
      gone_q       <= gone_d;
      res_status_q <= res_status_d;
      res_value_q  <= res_value_d;
      ov_q         <= ov_d;
      o_status_q   <= o_status_d;
      o_value_q    <= o_value_d;
      o_pos_q      <= o_pos_d;
      o_cnt_q      <= o_cnt_d;
      o_last_q     <= o_last_d;
    end
  end

  // result beat packing
  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = {2'b00, o_cnt_q, o_pos_q, o_value_q};
  assign m_axis_tuser  = o_status_q;
  assign m_axis_tlast  = o_last_q;

endmodule

`default_nettype wire

// File: sim/positional_array_table_tb.sv
// self-checking testbench for the positional array table: table predictor, stream drivers, run control
`timescale 1ns / 100ps

module positional_array_table_tb;
  import pat_pkg::*;

  localparam int unsigned TABLE_DEPTH = 64;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned DRAIN_CYCLES = 100;
  localparam int unsigned REPORT_MAX = 10;

  // op codes outside the defined set, the block must answer them with a plain ok
  localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

  // one predicted result beat
  typedef struct {
    status_e          status;
    logic [VAL_W-1:0] value;
    logic [POS_W-1:0] position;
    logic [CNT_W-1:0] count;
    logic             last;
  } table_result_t;

  // mirror of the table contents plus the queue of predicted result beats
  class table_scoreboard;
    logic [VAL_W-1:0] words [TABLE_DEPTH];
    int unsigned      held;
    table_result_t    pending_q [$];
    int unsigned      failures;
    int unsigned      beats_seen;

    function new();
      held = 0;
      failures = 0;
      beats_seen = 0;
    endfunction

    function void push_result(status_e st, logic [VAL_W-1:0] v, int unsigned p, logic l);
      table_result_t r;
      r.status = st;
      r.value = v;
      r.position = POS_W'(p);
      r.count = CNT_W'(held);
      r.last = l;
      pending_q.push_back(r);
    endfunction

    // apply one accepted request to the mirror and queue its result beats
    function void note_request(logic [OP_W-1:0] op, logic [POS_W-1:0] pos_in,
                               logic [VAL_W-1:0] word);
      int p;
      int k;
      int hit;
      logic [VAL_W-1:0] gone;
      p = int'(pos_in);
      case (op)
        OP_APPEND: begin
          if (held >= TABLE_DEPTH) begin
            push_result(STAT_FULL, '0, 0, 1'b1);
          end else begin
            words[held] = word;
            held++;
            push_result(STAT_OK, '0, 0, 1'b1);
          end
        end
        OP_INSERT: begin
          if (held >= TABLE_DEPTH) begin
            push_result(STAT_FULL, '0, 0, 1'b1);
          end else if (p < 1 || p > int'(held) + 1) begin
            push_result(STAT_BAD_POS, '0, 0, 1'b1);
          end else begin
            for (k = int'(held); k >= p; k--) words[k] = words[k-1];
            words[p-1] = word;
            held++;
            push_result(STAT_OK, '0, 0, 1'b1);
          end
        end
        OP_DELETE: begin
          if (held == 0) begin
            push_result(STAT_EMPTY, '0, 0, 1'b1);
          end else if (p < 1 || p > int'(held)) begin
            push_result(STAT_BAD_POS, '0, 0, 1'b1);
          end else begin
            gone = words[p-1];
            for (k = p - 1; k + 1 < int'(held); k++) words[k] = words[k+1];
            held--;
            push_result(STAT_OK, gone, 0, 1'b1);
          end
        end
        OP_SEARCH: begin
          // first matching position wins
          hit = -1;
          for (k = 0; k < int'(held); k++) begin
            if (hit < 0 && words[k] == word) hit = k;
          end
          if (hit < 0) push_result(STAT_NOT_FOUND, '0, 0, 1'b1);
          else push_result(STAT_OK, words[hit], hit + 1, 1'b1);
        end
        OP_UPDATE: begin
          if (p < 1 || p > int'(held)) begin
            push_result(STAT_BAD_POS, '0, 0, 1'b1);
          end else begin
            words[p-1] = word;
            push_result(STAT_OK, '0, 0, 1'b1);
          end
        end
        OP_TRAVERSE: begin
          if (held == 0) begin
            push_result(STAT_EMPTY, '0, 0, 1'b1);
          end else begin
            for (k = 0; k < int'(held); k++)
              push_result(STAT_OK, words[k], k + 1, (k + 1 == int'(held)));
          end
        end
        default: push_result(STAT_OK, '0, 0, 1'b1);
      endcase
    endfunction

    // compare one accepted result beat with the oldest prediction
    function void check_result(logic [OUT_DATA_W-1:0] data, logic [STAT_W-1:0] stat,
                               logic l);
      table_result_t e;
      beats_seen++;
      if (pending_q.size() == 0) begin
        failures++;
        if (failures <= REPORT_MAX)
          $display("result beat %0d arrived with nothing predicted: status %0d data %h last %0b",
                   beats_seen, stat, data, l);
        return;
      end
      e = pending_q.pop_front();
      if (stat != e.status || data[31:0] != e.value || data[38:32] != e.position ||
          data[45:39] != e.count || l != e.last) begin
        failures++;
        if (failures <= REPORT_MAX) begin
          $display("result beat %0d differs", beats_seen);
          $display("  expected status %0d value %h position %0d count %0d last %0b",
                   e.status, e.value, e.position, e.count, e.last);
          $display("  got      status %0d value %h position %0d count %0d last %0b",
                   stat, data[31:0], data[38:32], data[45:39], l);
        end
      end
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;   // position, value, pad
  logic [OP_W-1:0]       s_axis_tuser;   // op
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;   // result_value, result_position, count, pad
  logic [STAT_W-1:0]     m_axis_tuser;   // status
  logic                  m_axis_tlast;

  table_scoreboard sb;
  int unsigned     idle_pct;
  int unsigned     stall_pct;
  int unsigned     cycle_count;

  positional_array_table DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // 12 ns clock
  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // result side backpressure
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // beat monitor on both streams
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
    if (rst_ni && s_axis_tvalid && s_axis_tready)
      sb.note_request(s_axis_tuser, s_axis_tdata[6:0], s_axis_tdata[38:7]);
  end

  // hang guard
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("positional_array_table: mismatch");
      $finish;
    end
  end

  // present one request from a falling edge, return at the falling edge after it is accepted
  task automatic send_request(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                              input logic [VAL_W-1:0] word);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(0, 99) < idle_pct) gap++;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {1'b0, word, pos};
    s_axis_tuser <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  // word mix: extremes, a small pool for duplicates, and full random
  function automatic logic [VAL_W-1:0] pick_word();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return VAL_W'($urandom_range(0, 7));
      3: return -VAL_W'($urandom_range(1, 4));
      default: return $urandom;
    endcase
  endfunction

  // mostly legal positions, some on the edges, some anywhere in the field
  function automatic logic [POS_W-1:0] pick_position(int unsigned top);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 80 && top >= 1) return POS_W'($urandom_range(1, top));
    if (r < 90) return ($urandom_range(0, 1) == 1) ? POS_W'(top + 1) : '0;
    return POS_W'($urandom_range(0, 127));
  endfunction

  // random requests biased toward growing or shrinking the table
  task automatic random_requests(int unsigned n, int unsigned add_pct, int unsigned del_pct);
    int unsigned r;
    int unsigned i;
    logic [OP_W-1:0]  op;
    logic [POS_W-1:0] pos;
    logic [VAL_W-1:0] word;
    for (i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      word = pick_word();
      pos = POS_W'($urandom_range(0, 127));
      if (r < add_pct) begin
        if ($urandom_range(0, 1) == 1) begin
          op = OP_APPEND;
        end else begin
          op = OP_INSERT;
          pos = pick_position(sb.held + 1);
        end
      end else if (r < add_pct + del_pct) begin
        op = OP_DELETE;
        pos = pick_position(sb.held);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 40) begin
          op = OP_SEARCH;
          if (sb.held > 0 && $urandom_range(0, 2) != 0)
            word = sb.words[$urandom_range(0, sb.held - 1)];
        end else if (r < 70) begin
          op = OP_UPDATE;
          pos = pick_position(sb.held);
        end else if (r < 90) begin
          op = OP_TRAVERSE;
        end else begin
          op = ($urandom_range(0, 1) == 1) ? OP_SPARE_HI : OP_SPARE_LO;
        end
      end
      send_request(op, pos, word);
    end
  endtask

  initial begin
    sb = new();
    idle_pct = 0;
    stall_pct = 0;
    cycle_count = 0;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    m_axis_tready = 1'b0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    // empty table corners
    send_request(OP_TRAVERSE, 7'd0, 32'h0);
    send_request(OP_DELETE, 7'd1, 32'h0);
    send_request(OP_SEARCH, 7'd0, 32'h0);
    send_request(OP_UPDATE, 7'd1, 32'h1234_5678);
    send_request(OP_INSERT, 7'd0, 32'h1);
    send_request(OP_INSERT, 7'd2, 32'h1);
    // fill with extremes, insert at front, middle and end
    send_request(OP_INSERT, 7'd1, 32'h8000_0000);
    send_request(OP_APPEND, 7'd127, 32'h7fff_ffff);
    send_request(OP_APPEND, 7'd0, 32'h0);
    send_request(OP_APPEND, 7'd0, 32'hffff_ffff);
    send_request(OP_INSERT, 7'd2, 32'h5);
    send_request(OP_INSERT, 7'd6, 32'd123);
    // search hit and miss, update legal and out of range
    send_request(OP_SEARCH, 7'd0, 32'hffff_ffff);
    send_request(OP_SEARCH, 7'd0, 32'd999);
    send_request(OP_UPDATE, 7'd1, 32'h5555_5555);
    send_request(OP_UPDATE, 7'd127, 32'haaaa_aaaa);
    // delete out of range, last and first
    send_request(OP_DELETE, 7'd0, 32'h0);
    send_request(OP_DELETE, 7'd6, 32'h0);
    send_request(OP_DELETE, 7'd1, 32'h0);
    // unused op codes
    send_request(OP_SPARE_LO, 7'd1, 32'h0);
    send_request(OP_SPARE_HI, 7'd127, 32'hffff_ffff);
    send_request(OP_TRAVERSE, 7'd0, 32'h0);

    // grow to full with no idling
    random_requests(90, 85, 5);
    // shrink with an idle sender
    idle_pct = 72;
    random_requests(80, 10, 75);
    // grow again against a stalling receiver
    idle_pct = 0;
    stall_pct = 72;
    random_requests(90, 85, 5);
    // shrink with light idling on both sides
    idle_pct = 11;
    stall_pct = 11;
    random_requests(70, 5, 85);

    s_axis_tvalid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.failures == 0 && sb.pending_q.size() == 0) begin
      $display("positional_array_table: match");
    end else begin
      $display("positional_array_table: mismatch");
    end
    $finish;
  end

endmodule
